// File: rtl/assert_macros.svh
// shared assertion macros for the scanner checkers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, quiet while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_DOT,
        MODE_FLOAT,
        MODE_IDENT
    } t_mode;

    typedef enum logic [2:0] {
        KIND_END   = 3'd0,
        KIND_UINT  = 3'd1,
        KIND_FLOAT = 3'd2,
        KIND_IDENT = 3'd3,
        KIND_OP    = 3'd4,
        KIND_BAD   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [7:0]  len;
        logic [7:0]  opc;
        logic        too_long;
        logic        last;
    } t_token;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    // result queue: one item makes at most three results
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HT     = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_UC_A) && (c <= CH_UC_Z)) || ((c >= CH_LC_A) && (c <= CH_LC_Z));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
    endfunction

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_PLUS) ||
               (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) ||
               (c == CH_EQUAL) || (c == CH_COMMA);
    endfunction

endpackage

`default_nettype wire

// File: rtl/script_token_scanner.sv
// channel  | dir | tdata                  | tuser      | tlast
// ---------+-----+------------------------+------------+--------------------
// s (char) | in  | char_code              | -          | end_of_input
// m (tok)  | out | offset/length/char/flg | token_kind | last token of char
//
// one character is scanned per cycle; the mode update and the token build are one
// level of decode between the state registers and a four-entry result queue
// a character makes zero to three tokens; the queue drains one token per cycle,
// so a stream is held at one character per cycle while results fit the m side
// o_s_tready is high while the queue holds at most one token
// reset (i_rst_n low, synchronous) clears the scan state, offsets and the queue
`default_nettype none

module script_token_scanner #(
    parameter int LEXEME_LIMIT = 255
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire  [sts_pkg::S_TDATA_W-1:0] i_s_tdata,  // [7:0] char_code
    input  wire                           i_s_tlast,  // end_of_input
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    // [31:0] start_offset, [39:32] token_length, [47:40] operator_char,
    // [48] too_long, [55:49] zero
    output logic [sts_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic [sts_pkg::M_TUSER_W-1:0] o_m_tuser,  // [2:0] token_kind
    output logic                          o_m_tlast   // last_result
);

    localparam int LEN_CAP = (LEXEME_LIMIT < 255) ? LEXEME_LIMIT : 255;
    localparam logic [7:0] CAP8 = 8'(LEN_CAP);

    sts_pkg::t_mode r_mode, n_mode;
    logic [31:0]    r_start, n_start;
    logic [7:0]     r_len, n_len;
    logic [31:0]    r_offset, n_offset;
    logic           r_ovf, n_ovf;

    sts_pkg::t_token r_q [sts_pkg::QDEPTH];
    logic [sts_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [sts_pkg::QCNT_W-1:0] r_cnt;

    sts_pkg::t_token slot [sts_pkg::QDEPTH];
    sts_pkg::t_token tok_f0, tok_f1, tok_e, tok_out;
    logic [1:0] res_cnt, flush_cnt;
    logic       do_flush, e_valid, consumed;
    logic [7:0] c;
    logic [8:0] sum2;
    logic       s_fire, m_fire;

    assign c      = i_s_tdata[7:0];
    assign s_fire = i_s_tvalid && o_s_tready;
    assign m_fire = o_m_tvalid && i_m_tready;
    assign sum2   = {1'b0, r_len} + 9'd2;

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_offset = r_offset + 32'd1;
        consumed = 1'b0;
        do_flush = 1'b0;
        e_valid  = 1'b0;

        tok_f0 = '{kind: sts_pkg::KIND_UINT, start: r_start, len: r_len, opc: 8'd0,
                   too_long: r_ovf, last: 1'b0};
        unique case (r_mode)
            sts_pkg::MODE_FLOAT: tok_f0.kind = sts_pkg::KIND_FLOAT;
            sts_pkg::MODE_IDENT: tok_f0.kind = sts_pkg::KIND_IDENT;
            default:             tok_f0.kind = sts_pkg::KIND_UINT;
        endcase
        // a held dot with no digit after it is reported at its own offset
        tok_f1 = '{kind: sts_pkg::KIND_BAD, start: r_offset - 32'd1, len: 8'd1,
                   opc: sts_pkg::CH_DOT, too_long: 1'b0, last: 1'b0};
        tok_e  = '{kind: sts_pkg::KIND_BAD, start: r_offset, len: 8'd1, opc: c,
                   too_long: 1'b0, last: 1'b0};

        unique case (r_mode)
            sts_pkg::MODE_IDLE: flush_cnt = 2'd0;
            sts_pkg::MODE_DOT:  flush_cnt = 2'd2;
            default:            flush_cnt = 2'd1;
        endcase

        if (i_s_tlast) begin
            do_flush = 1'b1;
            e_valid  = 1'b1;
            tok_e    = '{kind: sts_pkg::KIND_END, start: r_offset, len: 8'd0, opc: 8'd0,
                         too_long: 1'b0, last: 1'b0};
            n_mode   = sts_pkg::MODE_IDLE;
            n_start  = 32'd0;
            n_len    = 8'd0;
            n_ovf    = 1'b0;
            n_offset = 32'd0;
        end else begin
            unique case (r_mode)
                sts_pkg::MODE_INT: begin
                    if (sts_pkg::is_digit(c)) begin
                        consumed = 1'b1;
                    end else if (c == sts_pkg::CH_DOT) begin
                        consumed = 1'b1;
                        n_mode   = sts_pkg::MODE_DOT;
                    end
                end
                sts_pkg::MODE_DOT: begin
                    if (sts_pkg::is_digit(c)) begin
                        consumed = 1'b1;
                        n_mode   = sts_pkg::MODE_FLOAT;
                    end
                end
                sts_pkg::MODE_FLOAT: consumed = sts_pkg::is_digit(c);
                sts_pkg::MODE_IDENT: begin
                    consumed = sts_pkg::is_digit(c) || sts_pkg::is_letter(c) ||
                               (c == sts_pkg::CH_UNDER);
                end
                default: consumed = 1'b0;
            endcase

            if (consumed) begin
                // the dot is counted together with the first fraction digit
                if (r_mode == sts_pkg::MODE_DOT) begin
                    n_len = (sum2 <= {1'b0, CAP8}) ? sum2[7:0] : CAP8;
                    n_ovf = r_ovf || (sum2 > {1'b0, CAP8});
                end else if (r_mode != sts_pkg::MODE_INT || c != sts_pkg::CH_DOT) begin
                    n_len = (r_len < CAP8) ? r_len + 8'd1 : r_len;
                    n_ovf = r_ovf || (r_len >= CAP8);
                end
            end else begin
                do_flush = 1'b1;
                n_mode   = sts_pkg::MODE_IDLE;
                if (sts_pkg::is_digit(c) || sts_pkg::is_letter(c)) begin
                    n_mode  = sts_pkg::is_digit(c) ? sts_pkg::MODE_INT : sts_pkg::MODE_IDENT;
                    n_start = r_offset;
                    n_len   = 8'd1;
                    n_ovf   = 1'b0;
                end else if (!sts_pkg::is_blank(c)) begin
                    e_valid = 1'b1;
                    if (sts_pkg::is_operator(c)) begin
                        tok_e.kind = sts_pkg::KIND_OP;
                    end
                end
            end
        end

        if (!do_flush) begin
            flush_cnt = 2'd0;
        end
        res_cnt = flush_cnt + {1'b0, e_valid};

        slot[0] = (flush_cnt != 2'd0) ? tok_f0 : tok_e;
        slot[1] = (flush_cnt == 2'd2) ? tok_f1 : tok_e;
        slot[2] = tok_e;
        slot[3] = tok_e;
        if (res_cnt != 2'd0) begin
            slot[res_cnt - 2'd1].last = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= sts_pkg::MODE_IDLE;
            r_start  <= 32'd0;
            r_len    <= 8'd0;
            r_offset <= 32'd0;
            r_ovf    <= 1'b0;
        end else if (s_fire) begin
            r_mode   <= n_mode;
            r_start  <= n_start;
            r_len    <= n_len;
            r_offset <= n_offset;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (s_fire) begin
                r_wr_ptr <= r_wr_ptr + sts_pkg::QPTR_W'(res_cnt);
            end
            if (m_fire) begin
                r_rd_ptr <= r_rd_ptr + sts_pkg::QPTR_W'(1);
            end
            r_cnt <= r_cnt + (s_fire ? sts_pkg::QCNT_W'(res_cnt) : '0)
                           - sts_pkg::QCNT_W'(m_fire);
        end
    end

    // each queue entry takes the token whose place after the write pointer it holds
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < sts_pkg::QDEPTH; i++) begin
            logic [sts_pkg::QPTR_W-1:0] offs;
            offs = sts_pkg::QPTR_W'(i) - r_wr_ptr;
            if (s_fire && ({1'b0, offs} < {1'b0, res_cnt})) begin
                r_q[i] <= slot[offs];
            end
        end
    end

    assign tok_out    = r_q[r_rd_ptr];
    assign o_s_tready = (r_cnt <= sts_pkg::QCNT_W'(1));
    assign o_m_tvalid = (r_cnt != '0);
    assign o_m_tdata  = {7'd0, tok_out.too_long, tok_out.opc, tok_out.len, tok_out.start};
    assign o_m_tuser  = tok_out.kind;
    assign o_m_tlast  = tok_out.last;

endmodule

`default_nettype wire

// File: rtl/sts_checker.sv
`default_nettype none

`include "assert_macros.svh"

module sts_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_s_tvalid,
    input wire                           i_s_tready,
    input wire                           i_s_tlast,
    input wire                           i_m_tvalid,
    input wire                           i_m_tready,
    input wire [sts_pkg::M_TDATA_W-1:0]  i_m_tdata,
    input wire [sts_pkg::M_TUSER_W-1:0]  i_m_tuser,
    input wire                           i_m_tlast
);

    logic [sts_pkg::M_TDATA_W+sts_pkg::M_TUSER_W:0] m_word;

    assign m_word = {i_m_tlast, i_m_tuser, i_m_tdata};

    // a stalled token stays offered
    `ASSERT_NEXT(a_m_valid_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid)

    // and its payload does not move
    `ASSERT_NEXT(a_m_data_hold, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, $stable(m_word))

    // the input side only stalls while tokens are queued
    `ASSERT_IMPLIES(a_stall_has_tokens, i_clk, i_rst_n, !i_s_tready, i_m_tvalid)

    // an end of stream always yields at least the end token
    `ASSERT_NEXT(a_end_yields_token, i_clk, i_rst_n, i_s_tvalid && i_s_tready && i_s_tlast, i_m_tvalid)

endmodule

bind script_token_scanner sts_checker u_sts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);

`default_nettype wire
